// ----- hdl/stereo_biquad_iir_filter_macros.svh -----
// Assertion macros used by the stereo biquad filter checker.
`ifndef STEREO_BIQUAD_IIR_FILTER_MACROS_SVH
`define STEREO_BIQUAD_IIR_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define SBQ_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stereo biquad filter: check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define SBQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stereo biquad filter: check failed");

`endif

// ----- hdl/sbq_pkg.sv -----
// Types, widths and register codes shared by the stereo biquad filter.
package sbq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 26;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = 5;
	localparam int REG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	// Register indexes (byte address is four times the index)
	localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A0 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A1 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A2 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B2 = 3'd5;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	typedef struct packed {
		sample_t sample_in;
		logic    channel;
		logic    buffer_end;
	} in_item_t;

	typedef struct packed {
		sample_t sample_out;
		logic    channel_out;
		logic    buffer_end_out;
	} out_item_t;

	// Classified item handed from the front end to the filter engine
	typedef struct packed {
		sample_t sample;
		logic    channel;
		logic    buffer_end;
		logic    filt;
		logic    ch_eff;
	} job_t;

	typedef struct packed {
		coef_t a0;
		coef_t a1;
		coef_t a2;
		coef_t b1;
		coef_t b2;
	} coef_set_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ----- hdl/stereo_biquad_iir_filter.sv -----
// Top level of the stereo biquad filter: register port, front end, queue, engine.
//
// Usage:
// - Input channel sample_valid/sample_ready carries one sample with its channel
//   number and buffer end mark; output channel result_valid/result_ready returns
//   exactly one result per sample, in order.
// - Registers (APB, byte address 4*index): enable, coef_a0, coef_a1, coef_a2,
//   coef_b1, coef_b2. Coefficients are signed Q3.22. The user must write them only
//   while idle; the block itself does not enforce this.
// - Throughput: one item per cycle while consecutive filtered samples alternate
//   channels and the receiver does not stall. A filtered sample that follows one
//   of the same channel waits for the history write-back from the sum/round/saturate
//   stage. Pass-through items (enable low) run at one per cycle unless stalled.
// - Reset clears the registers, the history of every channel and all pending
//   items. No clearing pass is needed.
// - When the receiver stalls, the result stays in the output register and up
//   to four more items are held (engine, queue and input stage) before
//   sample_ready drops.
module stereo_biquad_iir_filter #(
	parameter int NUM_CHANNELS   = 2,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sbq_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [sbq_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [sbq_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  sbq_pkg::in_item_t                 sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output sbq_pkg::out_item_t                result
);

	logic                           enable_q;
	sbq_pkg::coef_set_t             coefs_q;
	logic [sbq_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           wr_en;
	sbq_pkg::coef_t                 wr_coef;

	logic                           push;
	sbq_pkg::job_t                  push_data;
	logic                           pop;
	sbq_pkg::job_t                  pop_data;
	sbq_pkg::queue_stat_t           qstat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[sbq_pkg::CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign wr_coef = pwdata[sbq_pkg::COEF_BITS-1:0];

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			coefs_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				sbq_pkg::REG_ENABLE: begin
					enable_q <= pwdata[0];
				end
				sbq_pkg::REG_COEF_A0: begin
					coefs_q.a0 <= wr_coef;
				end
				sbq_pkg::REG_COEF_A1: begin
					coefs_q.a1 <= wr_coef;
				end
				sbq_pkg::REG_COEF_A2: begin
					coefs_q.a2 <= wr_coef;
				end
				sbq_pkg::REG_COEF_B1: begin
					coefs_q.b1 <= wr_coef;
				end
				sbq_pkg::REG_COEF_B2: begin
					coefs_q.b2 <= wr_coef;
				end
				default: begin
				end
			endcase
		end
	end

	// Register reads; coefficients come back sign extended
	always_comb begin
		case (reg_idx)
			sbq_pkg::REG_ENABLE:  prdata = {{(sbq_pkg::CFG_DATA_W-1){1'b0}}, enable_q};
			sbq_pkg::REG_COEF_A0: prdata = sbq_pkg::CFG_DATA_W'(coefs_q.a0);
			sbq_pkg::REG_COEF_A1: prdata = sbq_pkg::CFG_DATA_W'(coefs_q.a1);
			sbq_pkg::REG_COEF_A2: prdata = sbq_pkg::CFG_DATA_W'(coefs_q.a2);
			sbq_pkg::REG_COEF_B1: prdata = sbq_pkg::CFG_DATA_W'(coefs_q.b1);
			sbq_pkg::REG_COEF_B2: prdata = sbq_pkg::CFG_DATA_W'(coefs_q.b2);
			default:              prdata = '0;
		endcase
	end

	sbq_front #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.enable       (enable_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.push         (push),
		.push_data    (push_data),
		.qstat        (qstat)
	);

	sbq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	sbq_back #(
		.NUM_CHANNELS   (NUM_CHANNELS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.coefs        (coefs_q),
		.pop_data     (pop_data),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- hdl/sbq_front.sv -----
// Front end: accepts samples, classifies them and hands them to the queue.
module sbq_front #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  sbq_pkg::in_item_t sample,
	output logic              push,
	output sbq_pkg::job_t     push_data,
	input  sbq_pkg::queue_stat_t qstat
);

	localparam logic MULTI_CH = (NUM_CHANNELS > 1);

	logic          valid_q;
	sbq_pkg::job_t job_q;
	sbq_pkg::job_t job_new;
	logic          take;

	// Classify: filter or pass, and which history set to use
	always_comb begin
		job_new.sample     = sample.sample_in;
		job_new.channel    = sample.channel;
		job_new.buffer_end = sample.buffer_end;
		job_new.filt       = enable;
		job_new.ch_eff     = MULTI_CH ? sample.channel : 1'b0;
	end

	assign push         = valid_q && !qstat.full;
	assign sample_ready = !valid_q || !qstat.full;
	assign take         = sample_valid && sample_ready;
	assign push_data    = job_q;

	// Hold one classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job_new;
		end
	end

endmodule

// ----- hdl/sbq_queue.sv -----
// Two-entry queue between the front end and the filter engine.
module sbq_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sbq_pkg::job_t        push_data,
	input  logic                 pop,
	output sbq_pkg::job_t        pop_data,
	output sbq_pkg::queue_stat_t qstat
);

	sbq_pkg::job_t                  mem_q [sbq_pkg::QUEUE_DEPTH];
	logic [sbq_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [sbq_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [sbq_pkg::QPTR_W:0]       count_q;

	assign qstat.full  = (count_q == (sbq_pkg::QPTR_W+1)'(sbq_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/sbq_back.sv -----
// Filter engine: per-channel history, product stage and sum/round/saturate stage.
module sbq_back #(
	parameter int NUM_CHANNELS   = 2,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbq_pkg::coef_set_t   coefs,
	input  sbq_pkg::job_t        pop_data,
	input  sbq_pkg::queue_stat_t qstat,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output sbq_pkg::out_item_t   result
);

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SB       = sbq_pkg::SAMPLE_BITS;
	localparam int PROD_W   = SB + sbq_pkg::COEF_BITS;
	localparam int ACC_W    = PROD_W + 3;
	localparam logic signed [ACC_W-1:0] ROUND_C =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	// Per-channel history
	sbq_pkg::sample_t hx1_q [NUM_CHANNELS];
	sbq_pkg::sample_t hx2_q [NUM_CHANNELS];
	sbq_pkg::sample_t hy1_q [NUM_CHANNELS];
	sbq_pkg::sample_t hy2_q [NUM_CHANNELS];

	// Product stage
	logic                      v_s1;
	sbq_pkg::job_t             job_s1;
	sbq_pkg::sample_t          x1_s1;
	sbq_pkg::sample_t          y1_s1;
	logic signed [PROD_W-1:0]  p0_s1, p1_s1, p2_s1, p3_s1, p4_s1;

	// Result stage (output register)
	logic                      v_s2;
	sbq_pkg::out_item_t        res_s2;

	logic [CH_IDX_W-1:0]       rd_idx;
	logic [CH_IDX_W-1:0]       wr_idx;
	sbq_pkg::sample_t          x1_rd, x2_rd, y1_rd, y2_rd;
	logic signed [PROD_W-1:0]  p0, p1, p2, p3, p4;
	logic                      hazard;
	logic                      adv2;
	logic                      take1;
	logic                      wb;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_sh;
	sbq_pkg::sample_t          y_sat;
	sbq_pkg::sample_t          y_fin;

	// Read the history of the channel at the head of the queue
	assign rd_idx = CH_IDX_W'(pop_data.ch_eff);
	assign x1_rd  = hx1_q[rd_idx];
	assign x2_rd  = hx2_q[rd_idx];
	assign y1_rd  = hy1_q[rd_idx];
	assign y2_rd  = hy2_q[rd_idx];

	// Hold the head item while the same channel still awaits its write-back
	assign hazard = v_s1 && job_s1.filt && pop_data.filt
		&& (job_s1.ch_eff == pop_data.ch_eff);
	assign adv2   = !v_s2 || result_ready;
	assign take1  = !v_s1 || adv2;
	assign pop    = !qstat.empty && !hazard && take1;
	assign wb     = v_s1 && adv2 && job_s1.filt;
	assign wr_idx = CH_IDX_W'(job_s1.ch_eff);

	// Five products of the difference equation
	assign p0 = coefs.a0 * pop_data.sample;
	assign p1 = coefs.a1 * x1_rd;
	assign p2 = coefs.a2 * x2_rd;
	assign p3 = coefs.b1 * y1_rd;
	assign p4 = coefs.b2 * y2_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take1) begin
			v_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && pop) begin
			job_s1 <= pop_data;
			x1_s1  <= x1_rd;
			y1_s1  <= y1_rd;
			p0_s1  <= p0;
			p1_s1  <= p1;
			p2_s1  <= p2;
			p3_s1  <= p3;
			p4_s1  <= p4;
		end
	end

	// Sum, round half up, drop the fraction and clamp to the sample range
	always_comb begin
		acc = ACC_W'(p0_s1) + ACC_W'(p1_s1) + ACC_W'(p2_s1)
			- ACC_W'(p3_s1) - ACC_W'(p4_s1) + ROUND_C;
		acc_sh = acc >>> COEF_FRAC_BITS;
		if (acc_sh > SAT_MAX) begin
			y_sat = SAT_MAX[SB-1:0];
		end else if (acc_sh < SAT_MIN) begin
			y_sat = SAT_MIN[SB-1:0];
		end else begin
			y_sat = acc_sh[SB-1:0];
		end
		y_fin = job_s1.filt ? y_sat : job_s1.sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			res_s2.sample_out     <= y_fin;
			res_s2.channel_out    <= job_s1.channel;
			res_s2.buffer_end_out <= job_s1.buffer_end;
		end
	end

	// Shift the new input and output into the channel's history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				hx1_q[i] <= '0;
				hx2_q[i] <= '0;
				hy1_q[i] <= '0;
				hy2_q[i] <= '0;
			end
		end else if (wb) begin
			hx1_q[wr_idx] <= job_s1.sample;
			hx2_q[wr_idx] <= x1_s1;
			hy1_q[wr_idx] <= y_sat;
			hy2_q[wr_idx] <= y1_s1;
		end
	end

	assign result_valid = v_s2;
	assign result       = res_s2;

endmodule

// ----- hdl/sbq_checker.sv -----
// Port-level checks on the stereo biquad filter, bound to the top level.
`include "stereo_biquad_iir_filter_macros.svh"

module sbq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input logic               result_valid,
	input logic               result_ready,
	input sbq_pkg::out_item_t result
);

	// Input stage, two queue entries, product stage and output register
	localparam logic [2:0] CAPACITY = 3'd5;

	logic [2:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = sample_valid && sample_ready;
	assign out_acc = result_valid && result_ready;

	// Count items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`SBQ_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
	`SBQ_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result))
	`SBQ_ASSERT_IMPLY(a_no_invented, inflight_q == '0, !result_valid)
	`SBQ_ASSERT_IMPLY(a_ready_when_empty, inflight_q == '0, sample_ready)
	`SBQ_ASSERT_IMPLY(a_capacity, 1'b1, inflight_q <= CAPACITY)

endmodule

bind stereo_biquad_iir_filter sbq_checker u_sbq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
